FILE: src/atsse_pkg.sv
package atsse_pkg;

    localparam int DEPTH_DEF      = 256;
    localparam int VALUE_BITS_DEF = 32;

    // operation codes
    localparam logic [2:0] OP_APPEND = 3'd0;
    localparam logic [2:0] OP_SEARCH = 3'd1;
    localparam logic [2:0] OP_SORT   = 3'd2;
    localparam logic [2:0] OP_DELETE = 3'd3;
    localparam logic [2:0] OP_INSERT = 3'd4;
    localparam logic [2:0] OP_READ   = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_MISS  = 2'd3;

    typedef struct packed {
        logic [2:0]         operation;
        logic [7:0]         index;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [7:0]         position;
        logic signed [31:0] element;
        logic [8:0]         count;
    } rsp_t;

endpackage

FILE: src/array_table_sort_search_edit.sv
// Channel   Dir  Handshake             Payload
// --------  ---  --------------------  ---------------------------------------
// in        in   in_valid / in_ready   in_item  (operation, index, value)
// out       out  out_valid / out_ready out_item (status, position, element, count)
//
// Request flow: each request is decoded; append, unused codes and errors end there;
// read fetches one word, search scans down from the top to a match or the bottom,
// delete shifts the tail down, insert shifts it up and then writes the value, and
// sort runs bubble passes until one has no swap (passes <= n, n = count).
// Reset clears the count and both handshakes; element storage is not cleared, no sweep.
// in_ready is high only while idle; a finished result waits in the output register,
// so one more request is taken while out_ready is low; its result waits in S_DONE.
module array_table_sort_search_edit #(
    parameter int DEPTH      = atsse_pkg::DEPTH_DEF,
    parameter int VALUE_BITS = atsse_pkg::VALUE_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  atsse_pkg::req_t  in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output atsse_pkg::rsp_t  out_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > 8) ? CW : 8;

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_DECODE    = 9'b000000010,
        S_RD        = 9'b000000100,
        S_EX        = 9'b000001000,
        S_SORT_LD   = 9'b000010000,
        S_SORT_HD   = 9'b000100000,
        S_SORT_TAIL = 9'b001000000,
        S_INS_PUT   = 9'b010000000,
        S_DONE      = 9'b100000000
    } state_t;

    state_t                 state_reg, state_next;
    atsse_pkg::req_t        req_reg, req_next;
    logic [CW-1:0]          n_reg, n_next;
    logic [CW-1:0]          ptr_reg, ptr_next;
    logic [VALUE_BITS-1:0]  cur_reg, cur_next;
    logic                   swap_reg, swap_next;
    logic [1:0]             status_reg, status_next;
    logic [7:0]             pos_reg, pos_next;
    logic [VALUE_BITS-1:0]  elem_reg, elem_next;
    atsse_pkg::rsp_t        out_reg, out_next;
    logic                   out_valid_reg, out_valid_next;

    // memory port
    logic                   mem_we;
    logic [AW-1:0]          waddr;
    logic [VALUE_BITS-1:0]  wdata;
    logic [AW-1:0]          raddr;
    logic [VALUE_BITS-1:0]  rd_data;

    // derived values
    logic [VALUE_BITS-1:0]  val_v;
    logic [XW-1:0]          idx_x;
    logic [XW-1:0]          n_x;
    logic [CW-1:0]          ptr_m1;
    logic [CW-1:0]          n_m1;
    logic [CW-1:0]          idx_p1;
    logic                   idx_bad;
    logic                   full;
    logic                   gt;
    logic                   out_load;

    atsse_ram #(
        .DEPTH (DEPTH),
        .WIDTH (VALUE_BITS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rd_data)
    );

    assign val_v   = VALUE_BITS'(signed'(req_reg.value));
    assign idx_x   = XW'(req_reg.index);
    assign n_x     = XW'(n_reg);
    assign ptr_m1  = CW'(ptr_reg - 1'b1);
    assign n_m1    = CW'(n_reg - 1'b1);
    assign idx_p1  = CW'(idx_x + 1'b1);
    assign idx_bad = (idx_x >= n_x);
    assign full    = (n_reg == CW'(DEPTH));
    // the sort comparator: held element against the word just read
    assign gt      = signed'(cur_reg) > signed'(rd_data);

    // insert walks downward and reads one below the write slot
    always_comb
    begin
        priority if (state_reg == S_SORT_LD)
        begin
            raddr = '0;
        end
        else if (req_reg.operation == atsse_pkg::OP_INSERT)
        begin
            raddr = ptr_m1[AW-1:0];
        end
        else
        begin
            raddr = ptr_reg[AW-1:0];
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    always_comb
    begin
        state_next  = state_reg;
        req_next    = req_reg;
        n_next      = n_reg;
        ptr_next    = ptr_reg;
        cur_next    = cur_reg;
        swap_next   = swap_reg;
        status_next = status_reg;
        pos_next    = pos_reg;
        elem_next   = elem_reg;
        mem_we      = 1'b0;
        waddr       = '0;
        wdata       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next   = in_item;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                status_next = atsse_pkg::ST_OK;
                pos_next    = req_reg.index;
                elem_next   = '0;
                state_next  = S_DONE;
                unique case (req_reg.operation)
                    atsse_pkg::OP_APPEND:
                    begin
                        if (full)
                        begin
                            status_next = atsse_pkg::ST_FULL;
                        end
                        else
                        begin
                            mem_we = 1'b1;
                            waddr  = n_reg[AW-1:0];
                            wdata  = val_v;
                            n_next = CW'(n_reg + 1'b1);
                        end
                    end
                    atsse_pkg::OP_SEARCH:
                    begin
                        // scan from the top, first hit is the last match
                        if (n_reg == '0)
                        begin
                            status_next = atsse_pkg::ST_MISS;
                            pos_next    = '0;
                        end
                        else
                        begin
                            ptr_next   = n_m1;
                            state_next = S_RD;
                        end
                    end
                    atsse_pkg::OP_SORT:
                    begin
                        if (n_reg > CW'(1))
                        begin
                            state_next = S_SORT_LD;
                        end
                    end
                    atsse_pkg::OP_DELETE:
                    begin
                        if (idx_bad)
                        begin
                            status_next = atsse_pkg::ST_RANGE;
                        end
                        else if (idx_p1 == n_reg)
                        begin
                            n_next = n_m1;
                        end
                        else
                        begin
                            ptr_next   = idx_p1;
                            state_next = S_RD;
                        end
                    end
                    atsse_pkg::OP_INSERT:
                    begin
                        if (idx_bad)
                        begin
                            status_next = atsse_pkg::ST_RANGE;
                        end
                        else if (full)
                        begin
                            status_next = atsse_pkg::ST_FULL;
                        end
                        else
                        begin
                            ptr_next   = n_reg;
                            state_next = S_RD;
                        end
                    end
                    atsse_pkg::OP_READ:
                    begin
                        if (idx_bad)
                        begin
                            status_next = atsse_pkg::ST_RANGE;
                        end
                        else
                        begin
                            ptr_next   = CW'(idx_x);
                            state_next = S_RD;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_RD:
            begin
                state_next = S_EX;
            end

            S_EX:
            begin
                unique case (req_reg.operation)
                    atsse_pkg::OP_SEARCH:
                    begin
                        if (rd_data == val_v)
                        begin
                            pos_next   = 8'(ptr_reg);
                            state_next = S_DONE;
                        end
                        else if (ptr_reg == '0)
                        begin
                            status_next = atsse_pkg::ST_MISS;
                            pos_next    = '0;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            ptr_next   = ptr_m1;
                            state_next = S_RD;
                        end
                    end
                    atsse_pkg::OP_SORT:
                    begin
                        // keep the larger one in hand, drop the smaller behind
                        mem_we = 1'b1;
                        waddr  = ptr_m1[AW-1:0];
                        if (gt)
                        begin
                            wdata     = rd_data;
                            swap_next = 1'b1;
                        end
                        else
                        begin
                            wdata    = cur_reg;
                            cur_next = rd_data;
                        end
                        if (ptr_reg == n_m1)
                        begin
                            state_next = S_SORT_TAIL;
                        end
                        else
                        begin
                            ptr_next   = CW'(ptr_reg + 1'b1);
                            state_next = S_RD;
                        end
                    end
                    atsse_pkg::OP_DELETE:
                    begin
                        mem_we = 1'b1;
                        waddr  = ptr_m1[AW-1:0];
                        wdata  = rd_data;
                        if (ptr_reg == n_m1)
                        begin
                            n_next     = n_m1;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            ptr_next   = CW'(ptr_reg + 1'b1);
                            state_next = S_RD;
                        end
                    end
                    atsse_pkg::OP_INSERT:
                    begin
                        mem_we = 1'b1;
                        waddr  = ptr_reg[AW-1:0];
                        wdata  = rd_data;
                        if (ptr_reg == idx_p1)
                        begin
                            state_next = S_INS_PUT;
                        end
                        else
                        begin
                            ptr_next   = ptr_m1;
                            state_next = S_RD;
                        end
                    end
                    atsse_pkg::OP_READ:
                    begin
                        elem_next  = rd_data;
                        state_next = S_DONE;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_SORT_LD:
            begin
                state_next = S_SORT_HD;
            end

            S_SORT_HD:
            begin
                cur_next   = rd_data;
                swap_next  = 1'b0;
                ptr_next   = CW'(1);
                state_next = S_RD;
            end

            S_SORT_TAIL:
            begin
                mem_we = 1'b1;
                waddr  = n_m1[AW-1:0];
                wdata  = cur_reg;
                state_next = swap_reg ? S_SORT_LD : S_DONE;
            end

            S_INS_PUT:
            begin
                mem_we     = 1'b1;
                waddr      = AW'(idx_x);
                wdata      = val_v;
                n_next     = CW'(n_reg + 1'b1);
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_next.status   = status_reg;
            out_next.position = pos_reg;
            out_next.element  = 32'(signed'(elem_reg));
            out_next.count    = 9'(n_reg);
            out_valid_next    = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        ptr_reg    <= ptr_next;
        cur_reg    <= cur_next;
        swap_reg   <= swap_next;
        status_reg <= status_next;
        pos_reg    <= pos_next;
        elem_reg   <= elem_next;
        out_reg    <= out_next;
    end

    // count stays within the store
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= CW'(DEPTH))
        else $error("element count above depth");

    // writes never land past the current end of the list
    a_write_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (CW'(waddr) <= n_reg))
        else $error("store write beyond count");

    // only the sequencer's working states touch the store
    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_DECODE || state_reg == S_EX ||
                    state_reg == S_SORT_TAIL || state_reg == S_INS_PUT))
        else $error("store write from idle state");

    // an accepted transfer always starts with decode
    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_DECODE))
        else $error("accepted request not decoded");

    // count holds while idle
    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |=> (n_reg == $past(n_reg)))
        else $error("count moved while idle");

endmodule

FILE: src/atsse_ram.sv
// Element store: one write port, one read port, registered read data.
module atsse_ram #(
    parameter int DEPTH = atsse_pkg::DEPTH_DEF,
    parameter int WIDTH = atsse_pkg::VALUE_BITS_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
